>>> hdl/pcd_pkg.sv
// pcd_pkg: shared widths, defaults and the command/status structs
// between the prufer decoder controller and datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

    localparam int NODE_W        = 7;   // node_count register width
    localparam int IDX_W         = 6;   // node index width
    localparam int MAX_NODES_DEF = 64;
    localparam int MIN_NODES     = 3;

    // controller -> datapath commands
    typedef struct packed {
        logic load_wr;      // store entry, read its degree
        logic load_upd;     // write back raised degree, count entry
        logic clear;        // degrees back to one, load count and error cleared
        logic scan_init;    // pointer and decode index to zero
        logic scan_rd;      // read degree at pointer
        logic scan_inc;     // pointer plus one, saturating at node_count-1
        logic leaf_sp;      // leaf takes pointer
        logic leaf_u;       // leaf takes current code entry
        logic code_rd;      // read code entry at decode index
        logic deg_rd;       // latch code entry, read its degree
        logic deg_wr;       // write back lowered degree, next index
        logic emit_edge;
        logic emit_last;
        logic emit_bad;
    } t_pcd_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic load_last;    // entry being counted completes the sequence
        logic range_err;    // some entry of this sequence was out of range
        logic sp_at_end;    // pointer reached node_count-1
        logic deg_is_one;   // degree read back is one
        logic new_leaf;     // lowered degree is one and node lies behind pointer
        logic idx_done;     // all code entries consumed
    } t_pcd_sts;

endpackage

`default_nettype wire

>>> hdl/pcd_datapath.sv
// pcd_datapath: code store, degree store with valid bits, counters, pointer
// and the registered result stage; depends on pcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcd_datapath
    import pcd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [NODE_W-1:0] i_nodes,
    input  wire logic              i_seq_clr,
    input  wire logic [IDX_W-1:0]  i_code_value,
    input  wire t_pcd_cmd          i_cmd,
    output t_pcd_sts               o_sts,
    output logic                   o_result_valid,
    output logic [IDX_W-1:0]       o_edge_leaf,
    output logic [IDX_W-1:0]       o_edge_other,
    output logic                   o_last_edge,
    output logic                   o_bad_code
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    logic [IDX_W-1:0]  code_mem [MAX_NODES];
    logic [IDX_W-1:0]  deg_mem  [MAX_NODES];
    logic [MAX_NODES-1:0] r_deg_vld;

    logic [IDX_W-1:0]  r_v;
    logic              r_v_ok;
    logic [NODE_W-1:0] r_load_cnt;
    logic              r_range_err;
    logic [NODE_W-1:0] r_idx;
    logic [NODE_W-1:0] r_sp;
    logic [IDX_W-1:0]  r_leaf;
    logic [IDX_W-1:0]  r_u;
    logic [IDX_W-1:0]  r_deg_q;
    logic              r_deg_q_vld;
    logic [IDX_W-1:0]  r_code_q;

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_leaf;
    logic [IDX_W-1:0]  r_out_other;
    logic              r_out_last;
    logic              r_out_bad;

    logic [AW-1:0]     deg_raddr;
    logic [AW-1:0]     deg_waddr;
    logic [IDX_W-1:0]  deg_wdata;
    logic              deg_we;
    logic [IDX_W-1:0]  deg_eff;
    logic [IDX_W-1:0]  deg_dec;
    logic              v_in_range;

    assign v_in_range = {1'b0, i_code_value} < i_nodes;
    assign deg_eff    = r_deg_q_vld ? r_deg_q : IDX_W'(1);
    assign deg_dec    = deg_eff - IDX_W'(1);

    always_comb begin
        priority if (i_cmd.load_wr) begin
            deg_raddr = i_code_value[AW-1:0];
        end else if (i_cmd.deg_rd) begin
            deg_raddr = r_code_q[AW-1:0];
        end else begin
            deg_raddr = r_sp[AW-1:0];
        end
    end

    always_comb begin
        if (i_cmd.load_upd) begin
            deg_waddr = r_v[AW-1:0];
            deg_wdata = deg_eff + IDX_W'(1);
            deg_we    = r_v_ok;
        end else begin
            deg_waddr = r_u[AW-1:0];
            deg_wdata = deg_dec;
            deg_we    = i_cmd.deg_wr;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            code_mem[r_load_cnt[AW-1:0]] <= i_code_value;
        end
        if (i_cmd.code_rd) begin
            r_code_q <= code_mem[r_idx[AW-1:0]];
        end
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (i_cmd.load_wr || i_cmd.scan_rd || i_cmd.deg_rd) begin
            r_deg_q     <= deg_mem[deg_raddr];
            r_deg_q_vld <= r_deg_vld[deg_raddr];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_vld   <= '0;
            r_load_cnt  <= '0;
            r_range_err <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.emit_edge | i_cmd.emit_last | i_cmd.emit_bad;
            if (i_cmd.clear || i_seq_clr) begin
                r_deg_vld   <= '0;
                r_load_cnt  <= '0;
                r_range_err <= 1'b0;
            end else begin
                if (deg_we) begin
                    r_deg_vld[deg_waddr] <= 1'b1;
                end
                if (i_cmd.load_wr && !v_in_range) begin
                    r_range_err <= 1'b1;
                end
                if (i_cmd.load_upd) begin
                    r_load_cnt <= r_load_cnt + NODE_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_v    <= i_code_value;
            r_v_ok <= v_in_range;
        end
        if (i_cmd.scan_init) begin
            r_sp  <= '0;
            r_idx <= '0;
        end
        if (i_cmd.scan_inc && (r_sp < i_nodes - NODE_W'(1))) begin
            r_sp <= r_sp + NODE_W'(1);
        end
        if (i_cmd.deg_wr) begin
            r_idx <= r_idx + NODE_W'(1);
        end
        if (i_cmd.deg_rd) begin
            r_u <= r_code_q;
        end
        if (i_cmd.leaf_sp) begin
            r_leaf <= r_sp[IDX_W-1:0];
        end else if (i_cmd.leaf_u) begin
            r_leaf <= r_u;
        end
        if (i_cmd.emit_edge) begin
            r_out_leaf  <= r_leaf;
            r_out_other <= r_code_q;
            r_out_last  <= 1'b0;
            r_out_bad   <= 1'b0;
        end else if (i_cmd.emit_last) begin
            r_out_leaf  <= r_leaf;
            r_out_other <= IDX_W'(i_nodes - NODE_W'(1));
            r_out_last  <= 1'b1;
            r_out_bad   <= 1'b0;
        end else if (i_cmd.emit_bad) begin
            r_out_leaf  <= '0;
            r_out_other <= '0;
            r_out_last  <= 1'b1;
            r_out_bad   <= 1'b1;
        end
    end

    always_comb begin
        o_sts.load_last  = (r_load_cnt + NODE_W'(1)) >= (i_nodes - NODE_W'(2));
        o_sts.range_err  = r_range_err;
        o_sts.sp_at_end  = r_sp >= (i_nodes - NODE_W'(1));
        o_sts.deg_is_one = deg_eff == IDX_W'(1);
        o_sts.new_leaf   = (deg_dec == IDX_W'(1)) && ({1'b0, r_u} < r_sp);
        o_sts.idx_done   = r_idx == (i_nodes - NODE_W'(2));
    end

    assign o_result_valid = r_out_vld;
    assign o_edge_leaf    = r_out_leaf;
    assign o_edge_other   = r_out_other;
    assign o_last_edge    = r_out_last;
    assign o_bad_code     = r_out_bad;

endmodule

`default_nettype wire

>>> hdl/pcd_ctrl.sv
// pcd_ctrl: load and decode sequencer for the prufer decoder
// depends on pcd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcd_ctrl
    import pcd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_pcd_sts i_sts,
    output t_pcd_cmd      o_cmd,
    output logic          o_busy
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LOAD     = 8'b0000_0010,
        S_SCAN_RD  = 8'b0000_0100,
        S_SCAN_CHK = 8'b0000_1000,
        S_CODE_RD  = 8'b0001_0000,
        S_DEG_RD   = 8'b0010_0000,
        S_DEG_WR   = 8'b0100_0000,
        S_SPARE    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_wr = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_upd = 1'b1;
                if (!i_sts.load_last) begin
                    n_state = S_IDLE;
                end else if (i_sts.range_err) begin
                    o_cmd.emit_bad = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.sp_at_end) begin
                    o_cmd.leaf_sp = 1'b1;
                    n_state       = S_CODE_RD;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (i_sts.deg_is_one) begin
                    o_cmd.leaf_sp = 1'b1;
                    n_state       = S_CODE_RD;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_CODE_RD: begin
                if (i_sts.idx_done) begin
                    o_cmd.emit_last = 1'b1;
                    o_cmd.clear     = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.code_rd = 1'b1;
                    n_state       = S_DEG_RD;
                end
            end
            S_DEG_RD: begin
                o_cmd.deg_rd    = 1'b1;
                o_cmd.emit_edge = 1'b1;
                n_state         = S_DEG_WR;
            end
            S_DEG_WR: begin
                o_cmd.deg_wr = 1'b1;
                if (i_sts.new_leaf) begin
                    o_cmd.leaf_u = 1'b1;
                    n_state      = S_CODE_RD;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != S_IDLE;

endmodule

`default_nettype wire

>>> hdl/prufer_code_decoder_unit.sv
// prufer_code_decoder_unit: top level of the prufer sequence decoder
// holds the node_count register; instantiates pcd_ctrl and pcd_datapath (pcd_pkg)
`timescale 1ns / 1ps
`default_nettype none

// channel   | signals                                          | direction
// ----------+--------------------------------------------------+----------
// input     | start, i_code_value (busy is out)                | in
// result    | o_result_valid, o_edge_leaf, o_edge_other,       | out
//           | o_last_edge, o_bad_code                          |
// config    | i_cfg_we, i_cfg_wdata (node_count)               | in
//
// an entry transfer takes place when start is high and busy is low; each
// entry is a degree read, then a write back of the raised degree (busy high)
// after the last entry the decode runs: each pointer step over the degree
// memory (one read port, registered data) reads a degree and then checks it,
// but a pointer at node_count-1 is taken unread; each code entry is read, its
// degree read, then written back lowered; a closing step emits the last edge
// results come out one cycle each on o_result_valid; the receiver cannot
// stall them. reset is synchronous, active low, and sets node_count to 64
// degrees return to one through per-entry valid bits, all cleared at once

module prufer_code_decoder_unit
    import pcd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [IDX_W-1:0]  i_code_value,
    input  wire logic              i_cfg_we,
    input  wire logic [NODE_W-1:0] i_cfg_wdata,
    output logic                   o_result_valid,
    output logic [IDX_W-1:0]       o_edge_leaf,
    output logic [IDX_W-1:0]       o_edge_other,
    output logic                   o_last_edge,
    output logic                   o_bad_code
);

    logic [NODE_W-1:0] r_node_count;
    logic [NODE_W-1:0] nodes_eff;
    t_pcd_cmd          cmd;
    t_pcd_sts          sts;
    logic              ctrl_busy;
    logic              start_ok;

    // node_count register; any write also abandons a partly loaded sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(MAX_NODES_DEF);
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    // clamp to the supported node range
    always_comb begin
        priority if (r_node_count < NODE_W'(MIN_NODES)) begin
            nodes_eff = NODE_W'(MIN_NODES);
        end else if (r_node_count > NODE_W'(MAX_NODES)) begin
            nodes_eff = NODE_W'(MAX_NODES);
        end else begin
            nodes_eff = r_node_count;
        end
    end

    assign start_ok = start & ~ctrl_busy;
    assign busy     = ctrl_busy;

    pcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_ok),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    pcd_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nodes        (nodes_eff),
        .i_seq_clr      (i_cfg_we),
        .i_code_value   (i_code_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_edge_leaf    (o_edge_leaf),
        .o_edge_other   (o_edge_other),
        .o_last_edge    (o_last_edge),
        .o_bad_code     (o_bad_code)
    );

endmodule

`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for prufer_code_decoder_unit, with a built-in decode predictor
// depends on pcd_pkg and the decoder rtl (prufer_code_decoder_unit and its submodules)
`timescale 1ns / 1ps

module tb;
    import pcd_pkg::*;

    localparam int NODES        = MAX_NODES_DEF;
    localparam int IDLE_GUARD   = 8;      // covers an entry still being written back
    localparam int DRAIN_CYCLES = 400;    // longer than a full decode at 64 nodes
    localparam int STALL_LIMIT  = 5000;   // cycles with no transfer before giving up

    // one emitted tree edge, or the bad-code marker
    typedef struct packed {
        logic [IDX_W-1:0] leaf;
        logic [IDX_W-1:0] other;
        logic             last;
        logic             bad;
    } t_tree_edge;

    // how the entries of a random sequence are drawn
    typedef enum int {SPREAD, CLUSTERED, HUB} t_shape;

    // dut ports
    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [IDX_W-1:0]  i_code_value;
    logic              i_cfg_we;
    logic [NODE_W-1:0] i_cfg_wdata;
    logic              o_result_valid;
    logic [IDX_W-1:0]  o_edge_leaf;
    logic [IDX_W-1:0]  o_edge_other;
    logic              o_last_edge;
    logic              o_bad_code;

    // predictor state, kept at the block's widths
    logic [NODE_W-1:0] node_reg;
    logic [IDX_W-1:0]  code_mem [NODES];
    logic [IDX_W-1:0]  deg_mem  [NODES];
    logic [NODE_W-1:0] load_cnt;
    logic [NODE_W-1:0] scan_ptr;
    logic [IDX_W-1:0]  leaf_node;
    logic              seq_bad;

    // edges predicted but not yet seen on the result ports
    t_tree_edge pending_edges [$];
    t_tree_edge head;

    int errors;
    int entries_sent;
    int edges_seen;
    int bad_seen;
    int decodes_seen;
    int settings_used;
    int stall_cycles;
    bit burst;

    prufer_code_decoder_unit #(
        .MAX_NODES(NODES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_code_value  (i_code_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_result_valid(o_result_valid),
        .o_edge_leaf   (o_edge_leaf),
        .o_edge_other  (o_edge_other),
        .o_last_edge   (o_last_edge),
        .o_bad_code    (o_bad_code)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // node count as the block uses it: clamped to 3..MAX_NODES
    function automatic int tree_nodes(input logic [NODE_W-1:0] value);
        if (value < MIN_NODES) return MIN_NODES;
        if (value > NODES) return NODES;
        return value;
    endfunction

    // degrees back to one, load count and error flag cleared
    function automatic void restart_sequence();
        for (int i = 0; i < NODES; i++) deg_mem[i] = IDX_W'(1);
        load_cnt = '0;
        seq_bad  = 1'b0;
    endfunction

    function automatic void set_node_count(input logic [NODE_W-1:0] value);
        node_reg = value;
        restart_sequence();
    endfunction

    // append one expected result at the tail
    function automatic void queue_edge(input t_tree_edge e);
        pending_edges = {pending_edges, e};
    endfunction

    // move the pointer forward to the next node of degree one, never past n-1
    function automatic void seek_leaf(input int n);
        while (scan_ptr < n - 1 && deg_mem[scan_ptr[IDX_W-1:0]] != 1) scan_ptr++;
    endfunction

    // take one entry; after the last entry of a sequence queue the whole decode
    function automatic void predict_entry(input logic [IDX_W-1:0] value);
        int n;
        logic [IDX_W-1:0] u;
        n = tree_nodes(node_reg);
        code_mem[load_cnt[IDX_W-1:0]] = value;
        if (value >= n) seq_bad = 1'b1;
        else deg_mem[value] = deg_mem[value] + 1'b1;
        load_cnt++;
        if (load_cnt < n - 2) return;

        // any out-of-range entry replaces the edges by one flagged result
        if (seq_bad) begin
            queue_edge('{leaf: '0, other: '0, last: 1'b1, bad: 1'b1});
            restart_sequence();
            return;
        end

        scan_ptr = '0;
        seek_leaf(n);
        leaf_node = scan_ptr[IDX_W-1:0];
        for (int i = 0; i < n - 2; i++) begin
            u = code_mem[i];
            queue_edge('{leaf: leaf_node, other: u, last: 1'b0, bad: 1'b0});
            deg_mem[u] = deg_mem[u] - 1'b1;
            // a node that just became a leaf behind the pointer is taken at once
            if (deg_mem[u] == 1 && u < scan_ptr) begin
                leaf_node = u;
            end else begin
                if (scan_ptr < n - 1) scan_ptr++;
                seek_leaf(n);
                leaf_node = scan_ptr[IDX_W-1:0];
            end
        end
        queue_edge('{leaf: leaf_node, other: IDX_W'(n - 1), last: 1'b1, bad: 1'b0});
        restart_sequence();
    endfunction

    // ------------------------------------------------------------------
    // result checker: every strobed result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_edges.size() == 0) begin
                $error("result with nothing expected: leaf %0d other %0d last %0b bad %0b",
                       o_edge_leaf, o_edge_other, o_last_edge, o_bad_code);
                errors++;
            end else begin
                head = pending_edges.pop_front();
                if (o_edge_leaf !== head.leaf) begin
                    $error("edge_leaf: expected %0d, got %0d", head.leaf, o_edge_leaf);
                    errors++;
                end
                if (o_edge_other !== head.other) begin
                    $error("edge_other: expected %0d, got %0d", head.other, o_edge_other);
                    errors++;
                end
                if (o_last_edge !== head.last) begin
                    $error("last_edge: expected %0b, got %0b", head.last, o_last_edge);
                    errors++;
                end
                if (o_bad_code !== head.bad) begin
                    $error("bad_code: expected %0b, got %0b", head.bad, o_bad_code);
                    errors++;
                end
                if (head.bad) bad_seen++;
                else edges_seen++;
                if (head.last) decodes_seen++;
            end
        end
    end

    // watchdog: any transfer on either side restarts the count
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // sender gap; runs of back-to-back transfers switch on and off at random
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) burst = !burst;
        if (burst) return 0;
        return $urandom_range(0, 19);
    endfunction

    // one entry transfer; start is left high so a following entry can go
    // back to back, and is only touched once per falling edge
    task automatic send_code(input logic [IDX_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_code_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        entries_sent++;
        predict_entry(value);
    endtask

    // drop start, let every expected result arrive and any entry write-back finish
    task automatic settle_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_edges.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy !== 1'b0);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    // register write only while idle; it also abandons any partial sequence
    task automatic write_node_count(input logic [NODE_W-1:0] value);
        settle_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        set_node_count(value);
        settings_used++;
    endtask

    // one complete sequence for a tree of the given size, optionally with a bad entry
    task automatic send_tree(input int nodes, input bit corrupt);
        int len;
        int bad_at;
        logic [IDX_W-1:0] hub;
        logic [IDX_W-1:0] value;
        t_shape shape;
        len    = nodes - 2;
        bad_at = (corrupt && nodes < NODES) ? $urandom_range(0, len - 1) : -1;
        shape  = t_shape'($urandom_range(0, 2));
        hub    = IDX_W'($urandom_range(0, nodes - 1));
        for (int i = 0; i < len; i++) begin
            if (i == bad_at) begin
                value = IDX_W'($urandom_range(nodes, 63));
            end else begin
                case (shape)
                    SPREAD:    value = IDX_W'($urandom_range(0, nodes - 1));
                    CLUSTERED: value = IDX_W'($urandom_range(0, (nodes > 4) ? 3 : nodes - 1));
                    default:   value = ($urandom_range(0, 3) == 0) ?
                                       IDX_W'($urandom_range(0, nodes - 1)) : hub;
                endcase
            end
            send_code(value);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // three nodes: one entry per sequence, lowest and highest node, then a bad entry
    task automatic test_smallest_tree();
        write_node_count(7'd3);
        send_code(6'd0);
        send_code(6'd2);
        send_code(6'd63);
    endtask

    // counts below three behave as three
    task automatic test_clamped_count();
        write_node_count(7'd0);
        send_code(6'd1);
        write_node_count(7'd2);
        send_code(6'd2);
    endtask

    // four nodes: a star, then a bad first entry, then an entry equal to the count
    task automatic test_bad_entries();
        write_node_count(7'd4);
        send_code(6'd3);
        send_code(6'd3);
        send_code(6'd63);
        send_code(6'd1);
        send_code(6'd2);
        send_code(6'd4);
    endtask

    // a register write in the middle of a sequence throws the loaded part away
    task automatic test_abandoned_load();
        write_node_count(7'd5);
        send_code(6'd4);
        send_code(6'd4);
        write_node_count(7'd5);
        send_code(6'd0);
        send_code(6'd4);
        send_code(6'd2);
    endtask

    // random trees over many node counts, full size and the clamped top among them
    task automatic test_random_trees(input int target);
        int first;
        int phase;
        int nodes;
        int trees;
        logic [NODE_W-1:0] value;
        first = entries_sent;
        phase = 0;
        while (entries_sent - first < target) begin
            case (phase)
                0:       value = NODE_W'(NODES);
                1:       value = 7'd127;
                2:       value = 7'd3;
                3:       value = 7'd1;
                default: value = ($urandom_range(0, 7) == 0) ?
                                 NODE_W'(NODES) : NODE_W'($urandom_range(3, 16));
            endcase
            write_node_count(value);
            nodes = tree_nodes(value);
            trees = (nodes > 32) ? 1 : $urandom_range(2, 6);
            repeat (trees) send_tree(nodes, $urandom_range(0, 7) == 0);
            // now and then leave a partial sequence for the next write to abandon
            if (nodes > 3 && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, nodes - 3))
                    send_code(IDX_W'($urandom_range(0, 63)));
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_code_value = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        errors        = 0;
        entries_sent  = 0;
        edges_seen    = 0;
        bad_seen      = 0;
        decodes_seen  = 0;
        settings_used = 0;
        stall_cycles  = 0;
        burst         = 1'b0;

        // predictor out of reset: 64 nodes, empty sequence
        node_reg  = NODE_W'(NODES);
        scan_ptr  = '0;
        leaf_node = '0;
        for (int i = 0; i < NODES; i++) code_mem[i] = '0;
        restart_sequence();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_smallest_tree();
        test_clamped_count();
        test_bad_entries();
        test_abandoned_load();
        test_random_trees(414);

        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d entry transfers under %0d node_count settings, %0d decodes",
                 entries_sent, settings_used, decodes_seen);
        $display("checked %0d tree edges and %0d bad-code results, %0d mismatches",
                 edges_seen, bad_seen, errors);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
